@@ hw/rtl/bounded_fifo_evict_oldest_defines.svh @@
// assertion macros for the bounded fifo with eviction
// no dependencies; included by files that carry assertions
`ifndef BOUNDED_FIFO_EVICT_OLDEST_DEFINES_SVH
`define BOUNDED_FIFO_EVICT_OLDEST_DEFINES_SVH

`ifndef ASSERT_OFF
`define BFEO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BFEO_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BFEO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BFEO_ASSERT(lbl, clk, rst, prop, msg)
`define BFEO_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BFEO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ hw/rtl/bfeo_pkg.sv @@
// shared constants, codes and types of the bounded fifo with eviction
// no dependencies
package bfeo_pkg;

  localparam int DEPTH    = 32;
  localparam int ID_W     = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int LIMIT_W  = 6;
  localparam int OCC_W    = 6;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  // register index, taken from paddr[2]
  localparam logic REG_QUEUE_LIMIT = 1'b0;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_REMOVE  = 1'b1;

  localparam logic KIND_EVICT  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_MATCH,
    S_REMOVE,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_evict;
    logic do_append;
    logic do_match;
    logic do_remove;
    logic emit_evict;
    logic emit_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lim_zero;
    logic at_limit;
    logic any_match;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/bfeo_ctrl.sv @@
// controller state machine of the bounded fifo with eviction
// depends on bfeo_pkg
module bfeo_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                command,
  output logic                in_stall,
  input  bfeo_pkg::dp_stat_t  stat,
  output bfeo_pkg::ctrl_cmd_t cmd
);

  bfeo_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfeo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bfeo_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (command == bfeo_pkg::CMD_REMOVE) ? bfeo_pkg::S_MATCH : bfeo_pkg::S_ENQ;
        end
      end
      bfeo_pkg::S_ENQ: begin
        if (stat.lim_zero || !stat.at_limit) begin
          state_next = bfeo_pkg::S_STATUS;
        end
      end
      bfeo_pkg::S_MATCH:  state_next = bfeo_pkg::S_REMOVE;
      bfeo_pkg::S_REMOVE: state_next = bfeo_pkg::S_STATUS;
      bfeo_pkg::S_STATUS: begin
        if (stat.out_free) begin
          state_next = bfeo_pkg::S_IDLE;
        end
      end
      default: state_next = bfeo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      bfeo_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      bfeo_pkg::S_ENQ: begin
        if (!stat.lim_zero) begin
          if (stat.at_limit) begin
            cmd.do_evict   = stat.out_free;
            cmd.emit_evict = stat.out_free;
          end else begin
            cmd.do_append = 1'b1;
          end
        end
      end
      bfeo_pkg::S_MATCH:  cmd.do_match = 1'b1;
      bfeo_pkg::S_REMOVE: cmd.do_remove = 1'b1;
      bfeo_pkg::S_STATUS: cmd.emit_status = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/bfeo_dp.sv @@
// datapath of the bounded fifo with eviction: shift chain, match vector,
// fill count and output register; depends on bfeo_pkg and the defines header
`include "bounded_fifo_evict_oldest_defines.svh"

module bfeo_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bfeo_pkg::ID_W-1:0]    item_id,
  input  logic [bfeo_pkg::CNT_W-1:0]   eff_limit,
  input  bfeo_pkg::ctrl_cmd_t          cmd,
  output bfeo_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         kind,
  output logic [bfeo_pkg::ID_W-1:0]    evicted_id,
  output logic                         found,
  output logic [bfeo_pkg::OCC_W-1:0]   occupancy,
  output logic                         last
);

  logic [bfeo_pkg::ID_W-1:0]  entry [bfeo_pkg::DEPTH];
  logic [bfeo_pkg::ID_W-1:0]  id_reg;
  logic [bfeo_pkg::CNT_W-1:0] count;
  logic [bfeo_pkg::DEPTH-1:0] match_vec;
  logic [bfeo_pkg::DEPTH-1:0] shift_mask;
  logic                       found_reg;
  logic                       hit;

  // entries at and above the first match move down by one
  always_comb begin
    for (int i = 0; i < bfeo_pkg::DEPTH; i++) begin
      shift_mask[i] = |(match_vec & ({bfeo_pkg::DEPTH{1'b1}} >> (bfeo_pkg::DEPTH - 1 - i)));
    end
  end

  assign hit            = |match_vec;
  assign stat.any_match = hit;
  assign stat.lim_zero  = (eff_limit == '0);
  assign stat.at_limit  = (count >= eff_limit);
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_reg <= item_id;
    end
    if (cmd.do_evict) begin
      for (int i = 0; i < bfeo_pkg::DEPTH - 1; i++) begin
        entry[i] <= entry[i+1];
      end
    end
    if (cmd.do_append) begin
      entry[count[bfeo_pkg::IDX_W-1:0]] <= id_reg;
    end
    if (cmd.do_remove && hit) begin
      for (int i = 0; i < bfeo_pkg::DEPTH - 1; i++) begin
        if (shift_mask[i]) begin
          entry[i] <= entry[i+1];
        end
      end
    end
    if (cmd.do_match) begin
      for (int i = 0; i < bfeo_pkg::DEPTH; i++) begin
        match_vec[i] <= (entry[i] == id_reg) && (bfeo_pkg::CNT_W'(i) < count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      found_reg <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        found_reg <= 1'b0;
      end else if (cmd.do_remove && hit) begin
        found_reg <= 1'b1;
      end
      if (cmd.do_evict || (cmd.do_remove && hit)) begin
        count <= count - 1'b1;
      end else if (cmd.do_append) begin
        count <= count + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_evict || cmd.emit_status) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_evict) begin
      kind       <= bfeo_pkg::KIND_EVICT;
      evicted_id <= entry[0];
      found      <= 1'b0;
      occupancy  <= '0;
      last       <= 1'b0;
    end else if (cmd.emit_status) begin
      kind       <= bfeo_pkg::KIND_STATUS;
      evicted_id <= '0;
      found      <= found_reg;
      occupancy  <= bfeo_pkg::OCC_W'(count);
      last       <= 1'b1;
    end
  end

  `BFEO_ASSERT(a_count_max, clk, rst, count <= bfeo_pkg::CNT_W'(bfeo_pkg::DEPTH), "fill count above depth")
  `BFEO_ASSERT_IMPL(a_emit_free, clk, rst, cmd.emit_evict || cmd.emit_status, stat.out_free, "result written over a waiting result")
  `BFEO_ASSERT_IMPL(a_evict_nonempty, clk, rst, cmd.do_evict, count != '0, "eviction from an empty queue")
  `BFEO_ASSERT_NEXT(a_remove_count, clk, rst, cmd.do_remove && hit, count == $past(count) - 1'b1, "remove did not shrink the queue")

endmodule

@@ hw/rtl/bounded_fifo_evict_oldest.sv @@
// Bounded FIFO of 16-bit identifiers (32 entries) that evicts its oldest
// entries. An enqueue transaction (command 0) first evicts head entries while
// the occupancy is at or above queue_limit, returning one eviction report
// (kind 0) per entry, then appends the id; with queue_limit 0 nothing is
// stored. A remove transaction (command 1) deletes the first entry equal to
// item_id and closes the gap, keeping order. Each transaction ends with a
// status result (kind 1, last 1) carrying found and the new occupancy.
// Limits above 32 act as 32. An enqueue steps through load, evictions and
// append, then status; a remove steps through load, compare, compaction and
// status. An eviction or the status waits while the result register is held
// by out_stall; otherwise the controller steps the shift-register chain one
// operation per cycle. One transaction is worked on at a time; the next one is
// accepted while the final status still waits in the output register.
// queue_limit sits at byte address 0 of the register port (bits 5:0).
// depends on bfeo_pkg, bfeo_ctrl and bfeo_dp
module bounded_fifo_evict_oldest (
  input  logic                          clk,
  input  logic                          rst,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfeo_pkg::ADDR_W-1:0]   paddr,
  input  logic [bfeo_pkg::DATA_W-1:0]   pwdata,
  output logic [bfeo_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // command transactions
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [bfeo_pkg::ID_W-1:0]     item_id,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [bfeo_pkg::ID_W-1:0]     evicted_id,
  output logic                          found,
  output logic [bfeo_pkg::OCC_W-1:0]    occupancy,
  output logic                          last
);

  logic [bfeo_pkg::LIMIT_W-1:0] queue_limit;
  logic [bfeo_pkg::CNT_W-1:0]   eff_limit;
  bfeo_pkg::ctrl_cmd_t          cmd;
  bfeo_pkg::dp_stat_t           stat;

  // register port: no wait states, word select on paddr[2]
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_limit <= bfeo_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == bfeo_pkg::REG_QUEUE_LIMIT)) begin
      queue_limit <= pwdata[bfeo_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bfeo_pkg::REG_QUEUE_LIMIT) begin
      prdata = bfeo_pkg::DATA_W'(queue_limit);
    end
  end

  // limit saturates at the store depth so the store never overflows
  assign eff_limit = (queue_limit > bfeo_pkg::LIMIT_W'(bfeo_pkg::DEPTH))
                   ? bfeo_pkg::CNT_W'(bfeo_pkg::DEPTH)
                   : bfeo_pkg::CNT_W'(queue_limit);

  bfeo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfeo_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .item_id    (item_id),
    .eff_limit  (eff_limit),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .evicted_id (evicted_id),
    .found      (found),
    .occupancy  (occupancy),
    .last       (last)
  );

endmodule

@@ tb/tb_bounded_fifo_evict_oldest.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the bounded fifo with eviction: directed table, then random traffic
// depends on bfeo_pkg and bounded_fifo_evict_oldest; results checked against a shadow fifo
module tb_bounded_fifo_evict_oldest;
  import bfeo_pkg::*;

  // run length cap, far beyond the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_DIRECTED = 26;

  // register map: queue_limit at byte 0, the next word is not mapped
  localparam logic [ADDR_W-1:0] LIMIT_ADDR    = ADDR_W'({REG_QUEUE_LIMIT, 2'b00});
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = ADDR_W'({~REG_QUEUE_LIMIT, 2'b00});

  typedef enum logic [1:0] {
    ROW_ENQUEUE,
    ROW_REMOVE,
    ROW_SET_LIMIT,
    ROW_UNMAPPED
  } row_kind_t;

  // one row of the directed part; typed rows carry the status to be seen
  typedef struct packed {
    row_kind_t          row_kind;
    logic [ID_W-1:0]    value;
    logic               typed;
    logic               t_found;
    logic [OCC_W-1:0]   t_occ;
  } stim_row_t;

  typedef struct packed {
    logic               kind;
    logic [ID_W-1:0]    evicted_id;
    logic               found;
    logic [OCC_W-1:0]   occupancy;
    logic               last;
  } fifo_result_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CMD_ENQUEUE;
  logic [ID_W-1:0]    item_id = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic [ID_W-1:0]    evicted_id;
  logic               found;
  logic [OCC_W-1:0]   occupancy;
  logic               last;

  // shadow of the block: ordered ids (oldest first) and the limit register
  logic [ID_W-1:0]    shadow_ids [$];
  logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;
  // results still owed by the block, oldest first
  fifo_result_t       owed_results [$];

  int                 mismatches = 0;
  int unsigned        cycle_count = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 stall_left = 0;

  // directed rows: reset state, ends of the id range, head/middle/tail removal,
  // no match, duplicates, eviction, limit lowered below occupancy, unmapped write,
  // limit 0, limit above the depth
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_REMOVE,    16'h1234, 1'b1, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'h0000, 1'b1, 1'b0, 6'd1},
    '{ROW_ENQUEUE,   16'hffff, 1'b1, 1'b0, 6'd2},
    '{ROW_ENQUEUE,   16'haaaa, 1'b1, 1'b0, 6'd3},
    '{ROW_ENQUEUE,   16'h5555, 1'b1, 1'b0, 6'd4},
    '{ROW_REMOVE,    16'haaaa, 1'b1, 1'b1, 6'd3},
    '{ROW_REMOVE,    16'h0000, 1'b1, 1'b1, 6'd2},
    '{ROW_REMOVE,    16'h5555, 1'b1, 1'b1, 6'd1},
    '{ROW_REMOVE,    16'h5555, 1'b1, 1'b0, 6'd1},
    '{ROW_ENQUEUE,   16'h0001, 1'b0, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'hffff, 1'b0, 1'b0, 6'd0},
    '{ROW_REMOVE,    16'hffff, 1'b0, 1'b0, 6'd0},
    '{ROW_SET_LIMIT, 16'd2,    1'b0, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'h8000, 1'b0, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'h7fff, 1'b0, 1'b0, 6'd0},
    '{ROW_SET_LIMIT, 16'd1,    1'b0, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'h0f0f, 1'b0, 1'b0, 6'd0},
    '{ROW_UNMAPPED,  16'd0,    1'b0, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'hf0f0, 1'b0, 1'b0, 6'd0},
    '{ROW_SET_LIMIT, 16'd0,    1'b0, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'h3c3c, 1'b1, 1'b0, 6'd1},
    '{ROW_REMOVE,    16'hf0f0, 1'b1, 1'b1, 6'd0},
    '{ROW_ENQUEUE,   16'h3c3c, 1'b1, 1'b0, 6'd0},
    '{ROW_SET_LIMIT, 16'd63,   1'b0, 1'b0, 6'd0},
    '{ROW_ENQUEUE,   16'hc3c3, 1'b1, 1'b0, 6'd1},
    '{ROW_REMOVE,    16'hc3c3, 1'b1, 1'b1, 6'd0}
  };

  bounded_fifo_evict_oldest i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .item_id    (item_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .evicted_id (evicted_id),
    .found      (found),
    .occupancy  (occupancy),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // gap lengths: mostly short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ids from a small pool give duplicates, the rest spread over the whole range
  function automatic logic [ID_W-1:0] random_id();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return ID_W'($urandom_range(0, 7));
    if (r == 1) return $urandom_range(0, 1) ? '1 : '0;
    return ID_W'($urandom());
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // shadow fifo: apply one accepted command and queue the results it owes
  task automatic mirror_command(input logic cmd, input logic [ID_W-1:0] id,
                                input logic typed, input logic t_found,
                                input logic [OCC_W-1:0] t_occ);
    int           lim;
    int           i;
    logic         hit;
    fifo_result_t r;
    hit = 1'b0;
    if (cmd == CMD_ENQUEUE) begin
      // limits above the depth saturate, limit 0 leaves the store alone
      lim = (int'(shadow_limit) > DEPTH) ? DEPTH : int'(shadow_limit);
      if (lim > 0) begin
        while (shadow_ids.size() >= lim) begin
          r.kind       = KIND_EVICT;
          r.evicted_id = shadow_ids.pop_front();
          r.found      = 1'b0;
          r.occupancy  = '0;
          r.last       = 1'b0;
          owed_results.push_back(r);
        end
        shadow_ids.push_back(id);
      end
    end else begin
      // first match only, order of the rest kept
      for (i = 0; i < shadow_ids.size(); i++) begin
        if (shadow_ids[i] == id) begin
          shadow_ids.delete(i);
          hit = 1'b1;
          break;
        end
      end
    end
    r.kind       = KIND_STATUS;
    r.evicted_id = '0;
    r.found      = typed ? t_found : hit;
    r.occupancy  = typed ? t_occ : OCC_W'(shadow_ids.size());
    r.last       = 1'b1;
    owed_results.push_back(r);
  endtask

  // present one command transaction and hold it until accepted
  task automatic send_command(input logic cmd, input logic [ID_W-1:0] id,
                              input logic typed, input logic t_found,
                              input logic [OCC_W-1:0] t_occ);
    command  <= cmd;
    item_id  <= id;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    mirror_command(cmd, id, typed, t_found, t_occ);
  endtask

  task automatic idle_after_send();
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // wait until every owed result has come, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write while idle, then read the limit back
  task automatic write_register(input logic [ADDR_W-1:0] addr,
                                input logic [LIMIT_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_QUEUE_LIMIT) shadow_limit = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[LIMIT_W-1:0] !== shadow_limit)
      report_mismatch($sformatf("queue_limit read back %0d, wanted %0d",
                                prdata[LIMIT_W-1:0], shadow_limit));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one random command: removes mostly aim at an id that is held
  task automatic send_random(input int enq_pct);
    logic [ID_W-1:0] id;
    if ($urandom_range(0, 99) < enq_pct) begin
      send_command(CMD_ENQUEUE, random_id(), 1'b0, 1'b0, '0);
    end else begin
      if (shadow_ids.size() != 0 && $urandom_range(0, 99) < 65)
        id = shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
      else
        id = random_id();
      send_command(CMD_REMOVE, id, 1'b0, 1'b0, '0);
    end
    idle_after_send();
  endtask

  task automatic run_random(input int n_items, input int enq_pct, input bit pause_midway);
    int n;
    for (n = 0; n < n_items; n++) begin
      // hold off the sender until the block has nothing left to report
      if (pause_midway && n == n_items / 2) drain_results();
      send_random(enq_pct);
    end
  endtask

  // result side: random stall bursts, none while stall_pct is 0
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every accepted result transaction is matched with the oldest owed one
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0b id %h found %0b occ %0d last %0b",
                                  kind, evicted_id, found, occupancy, last));
      end else begin
        want = owed_results.pop_front();
        if (kind !== want.kind || evicted_id !== want.evicted_id || found !== want.found ||
            occupancy !== want.occupancy || last !== want.last)
          report_mismatch($sformatf(
            "wanted kind %0b id %h found %0b occ %0d last %0b, got %0b %h %0b %0d %0b",
            want.kind, want.evicted_id, want.found, want.occupancy, want.last,
            kind, evicted_id, found, occupancy, last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, walked in order with light idling on both sides
    idle_pct  = 20;
    stall_pct = 15;
    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      case (row.row_kind)
        ROW_SET_LIMIT: write_register(LIMIT_ADDR, row.value[LIMIT_W-1:0]);
        ROW_UNMAPPED:  write_register(UNMAPPED_ADDR, row.value[LIMIT_W-1:0]);
        default: begin
          send_command(row.row_kind == ROW_REMOVE ? CMD_REMOVE : CMD_ENQUEUE,
                       row.value, row.typed, row.t_found, row.t_occ);
          idle_after_send();
        end
      endcase
    end

    // limit still above the depth: mixed traffic, then fill the store right up
    idle_pct  = 30;
    stall_pct = 25;
    run_random(50, 55, 1'b0);
    while (shadow_ids.size() < DEPTH) send_random(100);

    // limit dropped to 1 on a full store: next enqueue evicts every entry
    write_register(LIMIT_ADDR, LIMIT_W'(1));
    send_command(CMD_ENQUEUE, random_id(), 1'b0, 1'b0, '0);
    run_random(20, 50, 1'b0);

    // enqueueing disabled
    write_register(LIMIT_ADDR, LIMIT_W'(0));
    run_random(20, 50, 1'b0);

    // back at the reset limit: a stretch with no idling, then one with idling, each with a pause
    write_register(LIMIT_ADDR, LIMIT_RESET);
    idle_pct  = 0;
    stall_pct = 0;
    run_random(40, 65, 1'b1);
    idle_pct  = 35;
    stall_pct = 30;
    run_random(40, 60, 1'b1);

    // small limit under heavy back-pressure
    write_register(LIMIT_ADDR, LIMIT_W'(3));
    stall_pct = 60;
    run_random(40, 60, 1'b0);

    // a few random limits inside and above the depth
    stall_pct = 25;
    for (k = 0; k < 3; k++) begin
      write_register(LIMIT_ADDR, LIMIT_W'($urandom_range(1, DEPTH - 1)));
      run_random(30, 55, 1'b0);
    end
    write_register(LIMIT_ADDR, LIMIT_W'($urandom_range(DEPTH + 1, 63)));
    run_random(30, 70, 1'b0);

    // let the last results drain, then wait for stragglers
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bfeo_pkg.sv
hw/rtl/bfeo_ctrl.sv
hw/rtl/bfeo_dp.sv
hw/rtl/bounded_fifo_evict_oldest.sv
tb/tb_bounded_fifo_evict_oldest.sv
